>>> rtl/gradient_edge_threshold_core_assert.svh
// Assertion helpers, clocked on i_clk and held off while i_rst_n is low.
`ifndef GRADIENT_EDGE_THRESHOLD_CORE_ASSERT_SVH
`define GRADIENT_EDGE_THRESHOLD_CORE_ASSERT_SVH

// Same-cycle implication.
`define GEDGE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GEDGE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gedge_pkg.sv
`timescale 1ns / 1ps

package gedge_pkg;

    localparam int CFG_W      = 12;
    localparam int CH_W       = 3;
    localparam int THR_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int ENTRY_W    = 2 * BYTE_W;
    localparam int PIX_W      = 11;
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_CHANNEL_COUNT  = 2'd2,
        CFG_EDGE_THRESHOLD = 2'd3
    } t_cfg_reg;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = 12'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = 12'd480;
    localparam logic [CH_W-1:0]  RST_CHANNEL_COUNT  = 3'd1;
    localparam logic [THR_W-1:0] RST_EDGE_THRESHOLD = 9'd100;

    localparam logic [BYTE_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [BYTE_W-1:0] EDGE_OFF = 8'd0;

    typedef struct packed {
        logic [BYTE_W-1:0] edge_value;
        logic [PIX_W-1:0]  pixel_column;
        logic [PIX_W-1:0]  pixel_row;
        logic              last_of_frame;
    } t_result;

    function automatic logic [BYTE_W-1:0] abs_diff(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    // Entry holds row half 0 in the low byte, half 1 in the high byte.
    function automatic logic [BYTE_W-1:0] entry_half(input logic [ENTRY_W-1:0] ent,
                                                     input logic sel);
        entry_half = sel ? ent[ENTRY_W-1:BYTE_W] : ent[BYTE_W-1:0];
    endfunction

endpackage

>>> rtl/gedge_ram.sv
`timescale 1ns / 1ps

module gedge_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> rtl/gradient_edge_threshold_core.sv
// Result path: once the word with channel 0 of pixel (x, y+1) is accepted, the result
// word for pixel (x, y) passes stage 1 into the output queue, behind queued words.
// Throughput: 1 input word per cycle, set by the line store read-modify-write loop;
// input stalls only while the 4-word output queue cannot take another result.
// Reset: synchronous, active low; clears counters, pipeline, output queue and loads
// register defaults. The line store is not cleared.
`timescale 1ns / 1ps
`include "gradient_edge_threshold_core_assert.svh"

module gradient_edge_threshold_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_sample_byte,
    input  logic        i_frame_start,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_edge_value,
    output logic [10:0] o_pixel_column,
    output logic [10:0] o_pixel_row,
    output logic        o_last_of_frame
);

    localparam int CFGW  = gedge_pkg::CFG_W;
    localparam int PXW   = gedge_pkg::PIX_W;
    localparam int BW    = gedge_pkg::BYTE_W;
    localparam int EW    = gedge_pkg::ENTRY_W;
    localparam int QD    = gedge_pkg::FIFO_DEPTH;
    localparam int QPW   = $clog2(QD);
    localparam int QCW   = $clog2(QD + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WCW   = (CW + 1 > CFGW) ? CW + 1 : CFGW;
    localparam int HCW   = (RW + 1 > CFGW) ? RW + 1 : CFGW;

    // configuration
    logic [CFGW-1:0]              r_image_width;
    logic [CFGW-1:0]              r_image_height;
    logic [gedge_pkg::CH_W-1:0]   r_channel_count;
    logic [gedge_pkg::THR_W-1:0]  r_edge_threshold;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width    <= gedge_pkg::RST_IMAGE_WIDTH;
            r_image_height   <= gedge_pkg::RST_IMAGE_HEIGHT;
            r_channel_count  <= gedge_pkg::RST_CHANNEL_COUNT;
            r_edge_threshold <= gedge_pkg::RST_EDGE_THRESHOLD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (gedge_pkg::t_cfg_reg'(i_cfg_index))
                gedge_pkg::CFG_IMAGE_WIDTH:    r_image_width    <= i_cfg_data;
                gedge_pkg::CFG_IMAGE_HEIGHT:   r_image_height   <= i_cfg_data;
                gedge_pkg::CFG_CHANNEL_COUNT:  r_channel_count  <= i_cfg_data[gedge_pkg::CH_W-1:0];
                gedge_pkg::CFG_EDGE_THRESHOLD: r_edge_threshold <= i_cfg_data[gedge_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // effective limits
    logic [WCW-1:0]             w_eff;
    logic [HCW-1:0]             h_eff;
    logic [gedge_pkg::CH_W-1:0] cc_eff;

    always_comb begin
        if (r_image_width == '0) begin
            w_eff = WCW'(1);
        end else if (WCW'(r_image_width) > WCW'(MAX_WIDTH)) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = WCW'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_eff = HCW'(1);
        end else if (HCW'(r_image_height) > HCW'(MAX_HEIGHT)) begin
            h_eff = HCW'(MAX_HEIGHT);
        end else begin
            h_eff = HCW'(r_image_height);
        end
        if (r_channel_count == '0) begin
            cc_eff = 3'd1;
        end else if (r_channel_count > 3'd4) begin
            cc_eff = 3'd4;
        end else begin
            cc_eff = r_channel_count;
        end
    end

    // position counters
    logic [1:0]    r_bip;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_sel;
    logic [1:0]    n_bip;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic          n_sel;

    logic [1:0]    bip_cur;
    logic [CW-1:0] col_cur;
    logic [RW-1:0] row_cur;
    logic          sel_cur;
    logic [WCW-1:0] col_ext;
    logic [HCW-1:0] row_ext;
    logic [CW:0]    col_p1;
    logic [CW-1:0]  addr_b;
    logic           in_accept;
    logic           ch0;
    logic           interior;
    logic           last_pix;

    assign in_accept = i_in_valid && o_in_ready;

    always_comb begin
        bip_cur  = i_frame_start ? '0 : r_bip;
        col_cur  = i_frame_start ? '0 : r_col;
        row_cur  = i_frame_start ? '0 : r_row;
        sel_cur  = i_frame_start ? 1'b0 : r_sel;
        col_ext  = WCW'(col_cur);
        row_ext  = HCW'(row_cur);
        col_p1   = {1'b0, col_cur} + 1'b1;
        addr_b   = (col_p1 == (CW + 1)'(MAX_WIDTH)) ? '0 : col_p1[CW-1:0];
        ch0      = (bip_cur == '0);
        interior = (row_ext >= HCW'(2)) && (row_ext + 1'b1 <= h_eff) &&
                   (col_cur != '0) && (col_ext + WCW'(2) <= w_eff);
        last_pix = (col_ext + WCW'(2) == w_eff) && (row_ext + 1'b1 == h_eff);

        n_bip = bip_cur;
        n_col = col_cur;
        n_row = row_cur;
        n_sel = sel_cur;
        if (({1'b0, bip_cur} + 3'd1) >= cc_eff) begin
            n_bip = '0;
            if (col_ext + 1'b1 >= w_eff) begin
                n_col = '0;
                n_sel = ~sel_cur;
                n_row = (row_ext + 1'b1 >= h_eff) ? '0 : row_cur + 1'b1;
            end else begin
                n_col = col_cur + 1'b1;
            end
        end else begin
            n_bip = bip_cur + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bip <= '0;
            r_col <= '0;
            r_row <= '0;
            r_sel <= 1'b0;
        end else if (in_accept) begin
            r_bip <= n_bip;
            r_col <= n_col;
            r_row <= n_row;
            r_sel <= n_sel;
        end
    end

    // stage 1: line store data returns
    logic           r_s1_valid;
    logic           r_s1_emit;
    logic [PXW-1:0] r_s1_col;
    logic [PXW-1:0] r_s1_row;
    logic           r_s1_last;
    logic [BW-1:0]  r_s1_cur;
    logic           r_s1_older;
    logic [CW-1:0]  r_s1_addr_a;
    logic [CW-1:0]  r_s1_addr_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
        end else begin
            r_s1_valid <= in_accept && ch0;
            r_s1_emit  <= in_accept && ch0 && interior;
        end
        r_s1_col    <= PXW'(col_cur);
        r_s1_row    <= PXW'(row_cur - 1'b1);
        r_s1_last   <= last_pix;
        r_s1_cur    <= i_sample_byte;
        r_s1_older  <= sel_cur;
        r_s1_addr_a <= col_cur;
        r_s1_addr_b <= addr_b;
    end

    logic [EW-1:0] ram_rd_a;
    logic [EW-1:0] ram_rd_b;
    logic          ram_we;
    logic [EW-1:0] ram_wdata;

    gedge_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r_s1_addr_a),
        .i_wdata   (ram_wdata),
        .i_raddr_a (col_cur),
        .i_raddr_b (addr_b),
        .o_rdata_a (ram_rd_a),
        .o_rdata_b (ram_rd_b)
    );

    // write issued in the read cycle of the following word is forwarded
    logic          r_fwd_valid;
    logic [CW-1:0] r_fwd_addr;
    logic [EW-1:0] r_fwd_data;
    logic [EW-1:0] r_prev_ent;

    logic [EW-1:0] ent_a;
    logic [EW-1:0] ent_b;
    logic [BW-1:0] gx;
    logic [BW-1:0] gy;
    logic [gedge_pkg::THR_W-1:0] mag;
    gedge_pkg::t_result push_word;

    always_comb begin
        ent_a = (r_fwd_valid && (r_fwd_addr == r_s1_addr_a)) ? r_fwd_data : ram_rd_a;
        ent_b = (r_fwd_valid && (r_fwd_addr == r_s1_addr_b)) ? r_fwd_data : ram_rd_b;
        gx = gedge_pkg::abs_diff(gedge_pkg::entry_half(ent_b, ~r_s1_older),
                                 gedge_pkg::entry_half(r_prev_ent, ~r_s1_older));
        gy = gedge_pkg::abs_diff(r_s1_cur, gedge_pkg::entry_half(ent_a, r_s1_older));
        mag = {1'b0, gx} + {1'b0, gy};
        ram_we    = r_s1_valid;
        ram_wdata = r_s1_older ? {r_s1_cur, ent_a[BW-1:0]} : {ent_a[EW-1:BW], r_s1_cur};
        push_word.edge_value    = (mag > r_edge_threshold) ? gedge_pkg::EDGE_ON
                                                           : gedge_pkg::EDGE_OFF;
        push_word.pixel_column  = r_s1_col;
        push_word.pixel_row     = r_s1_row;
        push_word.last_of_frame = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= ram_we;
        end
        r_fwd_addr <= r_s1_addr_a;
        r_fwd_data <= ram_wdata;
        if (r_s1_valid) begin
            r_prev_ent <= ent_a;
        end
    end

    // output queue
    gedge_pkg::t_result r_fifo [QD];
    logic [QPW-1:0] r_wr_ptr;
    logic [QPW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_count;
    logic           push;
    logic           pop;
    logic [QCW:0]   room_sum;

    assign push        = r_s1_valid && r_s1_emit;
    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && i_out_ready;
    assign room_sum    = (QCW + 1)'(r_count) + (QCW + 1)'(r_s1_emit);
    assign o_in_ready  = (room_sum < (QCW + 1)'(QD));

    assign o_edge_value    = r_fifo[r_rd_ptr].edge_value;
    assign o_pixel_column  = r_fifo[r_rd_ptr].pixel_column;
    assign o_pixel_row     = r_fifo[r_rd_ptr].pixel_row;
    assign o_last_of_frame = r_fifo[r_rd_ptr].last_of_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_fifo[r_wr_ptr] <= push_word;
        end
    end

    `GEDGE_ASSERT_NXT(a_store_write_follows_ch0, in_accept && ch0, ram_we, "line store write missing")
    `GEDGE_ASSERT_IMP(a_queue_no_overflow, push, (r_count != QCW'(QD)) || pop, "output queue overflow")
    `GEDGE_ASSERT_IMP(a_queue_count_bound, 1'b1, r_count <= QCW'(QD), "output queue count out of range")
    `GEDGE_ASSERT_IMP(a_result_is_interior, o_out_valid, (o_pixel_column != '0) && (o_pixel_row != '0), "border pixel emitted")

endmodule

>>> tb/tb_gradient_edge_threshold_core.sv
`timescale 1ns / 1ps

module tb_gradient_edge_threshold_core;

    localparam int MAX_W       = 2048;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYC  = 8;
    localparam int DIR_ROWS    = 31;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [7:0]         smp;
        logic               fs;
        logic               typed;
        gedge_pkg::t_result res;
    } t_stim_row;

    localparam gedge_pkg::t_result NO_RES     = '0;
    localparam gedge_pkg::t_result CENTER_ON  = '{gedge_pkg::EDGE_ON, 11'd1, 11'd1, 1'b1};
    localparam gedge_pkg::t_result CENTER_OFF = '{gedge_pkg::EDGE_OFF, 11'd1, 11'd1, 1'b1};

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index     = '0;
    logic [11:0] i_cfg_data      = '0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_sample_byte   = '0;
    logic        i_frame_start   = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b1;
    logic [7:0]  o_edge_value;
    logic [10:0] o_pixel_column;
    logic [10:0] o_pixel_row;
    logic        o_last_of_frame;

    gradient_edge_threshold_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_byte  (i_sample_byte),
        .i_frame_start  (i_frame_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_edge_value   (o_edge_value),
        .o_pixel_column (o_pixel_column),
        .o_pixel_row    (o_pixel_row),
        .o_last_of_frame(o_last_of_frame)
    );

    // predictor state
    logic [11:0] width_reg  = gedge_pkg::RST_IMAGE_WIDTH;
    logic [11:0] height_reg = gedge_pkg::RST_IMAGE_HEIGHT;
    logic [2:0]  chan_reg   = gedge_pkg::RST_CHANNEL_COUNT;
    logic [8:0]  thr_reg    = gedge_pkg::RST_EDGE_THRESHOLD;
    logic [7:0]  line_mem [0:2*MAX_W-1];
    logic [1:0]  pix_byte   = '0;
    logic [10:0] col_pos    = '0;
    logic [10:0] row_pos    = '0;
    logic        older_half = 1'b0;

    gedge_pkg::t_result pending_edges[$];
    gedge_pkg::t_result exp_r;
    t_stim_row   dir_tab [DIR_ROWS];
    int          err_count     = 0;
    int          quiet_cycles  = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic flag_mismatch(input string msg);
        err_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic void apply_idle(input t_idle_mode m);
        case (m)
            IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 48; stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 48; end
            default:   begin send_idle_pct = 12; stall_pct = 12; end
        endcase
    endfunction

    task automatic predict_gradient_edge(input logic [7:0] smp, input logic fs,
                                         output bit hit, output gedge_pkg::t_result res);
        int w, h, cc, x, r, older, newer, gx, gy, mag;
        hit = 1'b0;
        res = NO_RES;
        w  = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : int'(width_reg));
        h  = (height_reg == 0) ? 1 : ((height_reg > MAX_W) ? MAX_W : int'(height_reg));
        cc = (chan_reg == 0) ? 1 : ((chan_reg > 4) ? 4 : int'(chan_reg));
        if (fs) begin
            pix_byte   = '0;
            col_pos    = '0;
            row_pos    = '0;
            older_half = 1'b0;
        end
        if (pix_byte == 0) begin
            x     = int'(col_pos);
            r     = int'(row_pos);
            older = int'(older_half);
            newer = int'(!older_half);
            if (r >= 2 && r + 1 <= h && x >= 1 && x + 2 <= w) begin
                gx  = int'(line_mem[newer*MAX_W + x + 1]) - int'(line_mem[newer*MAX_W + x - 1]);
                gy  = int'(smp) - int'(line_mem[older*MAX_W + x]);
                mag = ((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy);
                res.edge_value    = (mag > int'(thr_reg)) ? gedge_pkg::EDGE_ON
                                                          : gedge_pkg::EDGE_OFF;
                res.pixel_column  = 11'(x);
                res.pixel_row     = 11'(r - 1);
                res.last_of_frame = (x + 2 == w && r + 1 == h);
                hit = 1'b1;
            end
            line_mem[older*MAX_W + x] = smp;
        end
        if (int'(pix_byte) + 1 >= cc) begin
            pix_byte = '0;
            if (int'(col_pos) + 1 >= w) begin
                col_pos    = '0;
                older_half = !older_half;
                if (int'(row_pos) + 1 >= h) row_pos = '0;
                else row_pos = row_pos + 11'd1;
            end else begin
                col_pos = col_pos + 11'd1;
            end
        end else begin
            pix_byte = pix_byte + 2'd1;
        end
    endtask

    // leaves i_in_valid high at the accepting edge
    task automatic send_sample(input logic [7:0] smp, input logic fs);
        bit hit;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_sample_byte <= smp;
        i_frame_start <= fs;
        do begin
            @(negedge i_clk);
            hit = o_in_ready;
            @(posedge i_clk);
        end while (!hit);
    endtask

    // leaves i_cfg_valid high at the accepting edge
    task automatic write_reg(input gedge_pkg::t_cfg_reg idx, input logic [11:0] val);
        bit hit;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(negedge i_clk);
            hit = o_cfg_ready;
            @(posedge i_clk);
        end while (!hit);
        case (idx)
            gedge_pkg::CFG_IMAGE_WIDTH:   width_reg  = val;
            gedge_pkg::CFG_IMAGE_HEIGHT:  height_reg = val;
            gedge_pkg::CFG_CHANNEL_COUNT: chan_reg   = val[2:0];
            default:                      thr_reg    = val[8:0];
        endcase
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_edges.size() != 0);
    endtask

    task automatic run_phase(input logic [11:0] w, input logic [11:0] h,
                             input logic [11:0] cc, input logic [11:0] thr,
                             input int n, input t_idle_mode mode, input bit hold_mid);
        int         k, style, base, spread, v;
        bit         top, hit;
        logic       fs;
        gedge_pkg::t_result res;
        t_idle_mode m;
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        write_reg(gedge_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(gedge_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(gedge_pkg::CFG_CHANNEL_COUNT, cc);
        write_reg(gedge_pkg::CFG_EDGE_THRESHOLD, thr);
        i_cfg_valid <= 1'b0;
        m = mode;
        apply_idle(m);
        style  = 0;
        base   = 0;
        spread = 0;
        for (k = 0; k < n; k++) begin
            if (k > 0 && k % 256 == 0) begin
                m = t_idle_mode'((int'(m) + 1) % 4);
                apply_idle(m);
            end
            if (hold_mid && k == n / 2) wait_drained();
            top = (pix_byte == 0 && col_pos == 0 && row_pos == 0);
            if (k == 0 || top) begin
                style  = int'($urandom_range(2));
                base   = int'($urandom_range(255));
                spread = (style == 1) ? 12 : 60;
            end
            // first word of a phase always restarts the frame; otherwise mostly
            // well-formed frames with the odd wrap or stray frame start
            fs = (k == 0) || (top ? ($urandom_range(99) < 80) : ($urandom_range(99) < 2));
            if (style == 0) begin
                v = int'($urandom_range(255));
            end else begin
                v = base + int'($urandom_range(2 * spread)) - spread;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            send_sample(v[7:0], fs);
            predict_gradient_edge(v[7:0], fs, hit, res);
            if (hit) pending_edges.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_edges.size() == 0) begin
                flag_mismatch($sformatf("unexpected word col %0d row %0d",
                                        o_pixel_column, o_pixel_row));
            end else begin
                exp_r = pending_edges.pop_front();
                if (o_edge_value !== exp_r.edge_value)
                    flag_mismatch($sformatf("edge_value %0d, expected %0d (col %0d row %0d)",
                                            o_edge_value, exp_r.edge_value,
                                            exp_r.pixel_column, exp_r.pixel_row));
                if (o_pixel_column !== exp_r.pixel_column)
                    flag_mismatch($sformatf("pixel_column %0d, expected %0d",
                                            o_pixel_column, exp_r.pixel_column));
                if (o_pixel_row !== exp_r.pixel_row)
                    flag_mismatch($sformatf("pixel_row %0d, expected %0d",
                                            o_pixel_row, exp_r.pixel_row));
                if (o_last_of_frame !== exp_r.last_of_frame)
                    flag_mismatch($sformatf("last_of_frame %0d, expected %0d (col %0d row %0d)",
                                            o_last_of_frame, exp_r.last_of_frame,
                                            exp_r.pixel_column, exp_r.pixel_row));
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                     quiet_cycles, pending_edges.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int      i;
        bit      hit;
        gedge_pkg::t_result res;
        for (i = 0; i < 2 * MAX_W; i++) line_mem[i] = '0;
        // 3x3 frames, channel count and threshold left at reset values
        dir_tab = '{
            '{8'd0,   1'b1, 1'b0, NO_RES}, '{8'd255, 1'b0, 1'b0, NO_RES},
            '{8'd0,   1'b0, 1'b0, NO_RES},
            '{8'd255, 1'b0, 1'b0, NO_RES}, '{8'd9,   1'b0, 1'b0, NO_RES},
            '{8'd0,   1'b0, 1'b0, NO_RES},
            '{8'd0,   1'b0, 1'b0, NO_RES}, '{8'd0,   1'b0, 1'b1, CENTER_ON},
            '{8'd0,   1'b0, 1'b0, NO_RES},
            // wraps into next frame without a start mark; magnitude equals threshold
            '{8'd0,   1'b0, 1'b0, NO_RES}, '{8'd0,   1'b0, 1'b0, NO_RES},
            '{8'd0,   1'b0, 1'b0, NO_RES},
            '{8'd0,   1'b0, 1'b0, NO_RES}, '{8'd77,  1'b0, 1'b0, NO_RES},
            '{8'd100, 1'b0, 1'b0, NO_RES},
            '{8'd0,   1'b0, 1'b0, NO_RES}, '{8'd0,   1'b0, 1'b1, CENTER_OFF},
            '{8'd0,   1'b0, 1'b0, NO_RES},
            // aborted frame
            '{8'd12,  1'b1, 1'b0, NO_RES}, '{8'd200, 1'b0, 1'b0, NO_RES},
            '{8'd33,  1'b0, 1'b0, NO_RES}, '{8'd4,   1'b0, 1'b0, NO_RES},
            // threshold plus one
            '{8'd0,   1'b1, 1'b0, NO_RES}, '{8'd0,   1'b0, 1'b0, NO_RES},
            '{8'd0,   1'b0, 1'b0, NO_RES},
            '{8'd0,   1'b0, 1'b0, NO_RES}, '{8'd200, 1'b0, 1'b0, NO_RES},
            '{8'd50,  1'b0, 1'b0, NO_RES},
            '{8'd0,   1'b0, 1'b0, NO_RES}, '{8'd51,  1'b0, 1'b1, CENTER_ON},
            '{8'd0,   1'b0, 1'b0, NO_RES}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(gedge_pkg::CFG_IMAGE_WIDTH, 12'd3);
        write_reg(gedge_pkg::CFG_IMAGE_HEIGHT, 12'd3);
        i_cfg_valid <= 1'b0;
        apply_idle(IDLE_NONE);
        for (i = 0; i < DIR_ROWS; i++) begin
            send_sample(dir_tab[i].smp, dir_tab[i].fs);
            predict_gradient_edge(dir_tab[i].smp, dir_tab[i].fs, hit, res);
            if (dir_tab[i].typed) pending_edges.push_back(dir_tab[i].res);
            else if (hit) pending_edges.push_back(res);
        end

        run_phase(12'd5,    12'd4,    12'd1, 12'd0,   150, IDLE_NONE, 1'b1);
        run_phase(12'd4095, 12'd3,    12'd1, 12'd200, 150, IDLE_NONE, 1'b0);
        run_phase(12'd7,    12'd6,    12'd3, 12'd50,  200, IDLE_SEND, 1'b0);
        run_phase(12'd3,    12'd4095, 12'd0, 12'd511, 200, IDLE_RECV, 1'b1);
        run_phase(12'd8,    12'd5,    12'd7, 12'd255, 200, IDLE_BOTH, 1'b0);
        run_phase(12'd1,    12'd4,    12'd2, 12'd30,  40,  IDLE_SEND, 1'b0);
        run_phase(12'd6,    12'd2,    12'd1, 12'd80,  40,  IDLE_RECV, 1'b0);
        run_phase(12'd0,    12'd0,    12'd4, 12'd90,  40,  IDLE_BOTH, 1'b0);
        run_phase(12'd16,   12'd8,    12'd1, 12'd120, 340, IDLE_NONE, 1'b1);
        run_phase(12'd9,    12'd3,    12'd2, 12'd510, 100, IDLE_BOTH, 1'b0);
        run_phase(12'd2048, 12'd3,    12'd1, 12'd100, 60,  IDLE_RECV, 1'b0);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/gedge_pkg.sv
rtl/gedge_ram.sv
rtl/gradient_edge_threshold_core.sv
tb/tb_gradient_edge_threshold_core.sv
